/* hdl/lelt_pkg.sv */
// package for the lower envelope line table
// holds sizes, status codes, sequencer states and divider types; no dependencies
package lelt_pkg;

    localparam int MaxLines   = 64;
    localparam int IdxW       = $clog2(MaxLines);
    localparam int CntW       = IdxW + 1;
    localparam int CoordW     = 32;
    localparam int NumW       = 34;   // numerator / denominator width for breakpoints

    localparam logic signed [63:0] XMin = -(64'sd1 <<< (CoordW - 1));
    localparam logic signed [63:0] XMax = (64'sd1 <<< (CoordW - 1)) - 64'sd1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_QUERY_OK = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_EQ_RD,
        S_EQ,
        S_LB_RD,
        S_LB_GO,
        S_LB_WAIT,
        S_UB_RD,
        S_UB_GO,
        S_UB_WAIT,
        S_CHECK,
        S_WL_RD,
        S_WL,
        S_WH_RD,
        S_WH,
        S_COMMIT,
        S_TRIM_HI,
        S_TRIM_LO,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PUT,
        S_Q_RD,
        S_Q_SCAN,
        S_Q_MUL,
        S_Q_SUM,
        S_OUT
    } state_t;

    // divider request: ceil or floor of num / den
    typedef struct packed {
        logic                   start;
        logic                   ceil_mode;
        logic signed [NumW-1:0] num;
        logic signed [NumW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [NumW-1:0] quot;
    } div_rsp_t;

endpackage

/* hdl/lower_envelope_line_table_core.sv */
// Lower envelope line table. An item is an insert (action 0) or a query (action 1) and
// produces one result. Items are handled one at a time; s_axis_tready is high only in idle.
// An insert runs the slope scan and removal walk, a breakpoint division per bound through
// the one shared serial divider (up to two, one more per removed line), and a shift of the
// table entries; a query runs the interval scan and multiply over the N stored lines (N up
// to 64). The table sits in one memory read through a registered port.
// depends on lelt_pkg and lelt_div
module lower_envelope_line_table_core
    import lelt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,   // action
    input  logic [95:0] s_axis_tdata,   // slope[31:0], intercept[63:32], point_x[95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // status[2:0], min_value[66:3], zero pad
);

    // table memory: slope, intercept, low, high
    logic [127:0] mem [MaxLines];
    logic [127:0] rd_reg;
    logic [IdxW-1:0] raddr, waddr;
    logic [127:0] wdata;
    logic         we;

    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic signed [CntW:0] i0_reg, i0_next, i1_reg, i1_next, p_reg, p_next;
    logic signed [CntW:0] mv_reg, mv_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next, x_reg, x_next;
    logic signed [63:0] lb_reg, lb_next, ub_reg, ub_next;
    logic [IdxW-1:0] k_reg, k_next;
    logic signed [63:0] prod_reg, prod_next, res_reg, res_next;
    status_t st_reg, st_next;
    logic out_v_reg, out_v_next;
    div_req_t dreq;
    div_rsp_t drsp;

    logic signed [31:0] r_a, r_b, r_lo, r_hi;
    assign r_a  = rd_reg[31:0];
    assign r_b  = rd_reg[63:32];
    assign r_lo = rd_reg[95:64];
    assign r_hi = rd_reg[127:96];

    lelt_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // memory port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_v_reg <= out_v_next;
        end
        i0_reg <= i0_next; i1_reg <= i1_next; p_reg <= p_next; mv_reg <= mv_next;
        a_reg <= a_next; b_reg <= b_next; x_reg <= x_next;
        lb_reg <= lb_next; ub_reg <= ub_next; k_reg <= k_next;
        prod_reg <= prod_next; res_reg <= res_next; st_reg <= st_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {5'd0, res_reg, st_reg};

    // sequencer
    always_comb begin
        logic signed [CntW:0] cnt_s;
        state_next = state_reg; count_next = count_reg; out_v_next = out_v_reg;
        i0_next = i0_reg; i1_next = i1_reg; p_next = p_reg; mv_next = mv_reg;
        a_next = a_reg; b_next = b_reg; x_next = x_reg;
        lb_next = lb_reg; ub_next = ub_reg; k_next = k_reg;
        prod_next = prod_reg; res_next = res_reg; st_next = st_reg;
        raddr = '0; waddr = '0; wdata = '0; we = 1'b0;
        dreq = '0;
        cnt_s = $signed({1'b0, count_reg});
        if (out_v_reg && m_axis_tready) out_v_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && !out_v_reg) begin
                    a_next = s_axis_tdata[31:0];
                    b_next = s_axis_tdata[63:32];
                    x_next = s_axis_tdata[95:64];
                    res_next = '0;
                    p_next = '0;
                    k_next = '0;
                    mv_next = '0;
                    if (s_axis_tuser) begin
                        if (count_reg == '0) begin
                            st_next = ST_EMPTY; state_next = S_OUT;
                        end else state_next = S_Q_RD;
                    end else if (count_reg == '0) begin
                        we = 1'b1; waddr = '0;
                        wdata = {32'(XMax), 32'(XMin), s_axis_tdata[63:32], s_axis_tdata[31:0]};
                        count_next = CntW'(1);
                        st_next = ST_INSERTED; state_next = S_OUT;
                    end else state_next = S_SCAN_RD;
                end
            end
            // find first slope not above a
            S_SCAN_RD: begin
                raddr = IdxW'(p_reg); state_next = S_SCAN;
            end
            S_SCAN: begin
                if (r_a > a_reg) begin
                    p_next = p_reg + 2'sd1;
                    if (p_reg + 1 == cnt_s) begin
                        i0_next = p_reg; i1_next = p_reg + 2'sd1; state_next = S_LB_RD;
                    end else state_next = S_SCAN_RD;
                end else begin
                    i0_next = p_reg - 2'sd1; i1_next = p_reg;
                    if (r_a == a_reg) begin
                        if (r_b <= b_reg) begin
                            st_next = ST_REJECTED; state_next = S_OUT;
                        end else begin
                            i1_next = p_reg + 2'sd1; state_next = S_LB_RD;
                        end
                    end else state_next = S_LB_RD;
                end
            end
            S_LB_RD: begin
                lb_next = XMin; ub_next = XMax;
                if (i0_reg >= 0) begin
                    raddr = IdxW'(i0_reg); state_next = S_LB_GO;
                end else state_next = S_UB_RD;
            end
            S_LB_GO: begin
                dreq.start = 1'b1; dreq.ceil_mode = 1'b1;
                dreq.num = NumW'(b_reg) - NumW'(r_b);
                dreq.den = NumW'(r_a) - NumW'(a_reg);
                state_next = S_LB_WAIT;
            end
            // back to the lower walk when it asked for the division
            S_LB_WAIT: begin
                if (drsp.done) begin
                    lb_next = 64'(drsp.quot);
                    state_next = (mv_reg == (CntW+1)'(2)) ? S_WL_RD : S_UB_RD;
                end
            end
            S_UB_RD: begin
                if (i1_reg < cnt_s) begin
                    raddr = IdxW'(i1_reg); state_next = S_UB_GO;
                end else state_next = S_CHECK;
            end
            S_UB_GO: begin
                dreq.start = 1'b1; dreq.ceil_mode = 1'b0;
                dreq.num = NumW'(r_b) - NumW'(b_reg);
                dreq.den = NumW'(a_reg) - NumW'(r_a);
                state_next = S_UB_WAIT;
            end
            S_UB_WAIT: begin
                if (drsp.done) begin
                    ub_next = 64'(drsp.quot);
                    state_next = (mv_reg == (CntW+1)'(1)) ? S_WH_RD : S_CHECK;
                end
            end
            // first emptiness check before walking
            S_CHECK: begin
                if (ub_reg < lb_reg || ub_reg < XMin || lb_reg > XMax) begin
                    st_next = ST_REJECTED; state_next = S_OUT;
                end else begin
                    mv_next = '0; state_next = S_WL_RD;
                end
            end
            // drop lower-index lines that the new line covers
            S_WL_RD: begin
                if (i0_reg >= 0) begin
                    raddr = IdxW'(i0_reg); state_next = S_WL;
                end else state_next = S_WH_RD;
            end
            S_WL: begin
                if (lb_reg <= 64'(r_lo)) begin
                    i0_next = i0_reg - 2'sd1;
                    if (i0_reg - 1 >= 0) begin
                        raddr = IdxW'(i0_reg - 1); state_next = S_LB_GO;
                        mv_next = (CntW+1)'(2);
                    end else begin
                        lb_next = XMin; state_next = S_WH_RD;
                    end
                end else state_next = S_WH_RD;
            end
            // drop higher-index lines that the new line covers
            S_WH_RD: begin
                mv_next = (CntW+1)'(1);
                if (i1_reg < cnt_s) begin
                    raddr = IdxW'(i1_reg); state_next = S_WH;
                end else state_next = S_COMMIT;
            end
            S_WH: begin
                if (64'(r_hi) <= ub_reg) begin
                    i1_next = i1_reg + 2'sd1;
                    if (i1_reg + 1 < cnt_s) begin
                        raddr = IdxW'(i1_reg + 1); state_next = S_UB_GO;
                    end else begin
                        ub_next = XMax; state_next = S_COMMIT;
                    end
                end else state_next = S_COMMIT;
            end
            S_COMMIT: begin
                mv_next = '0;
                if (lb_reg < XMin) lb_next = XMin;
                if (ub_reg > XMax) ub_next = XMax;
                if ((ub_reg > XMax ? XMax : ub_reg) < (lb_reg < XMin ? XMin : lb_reg)) begin
                    st_next = ST_REJECTED; state_next = S_OUT;
                end else if (cnt_s - (i1_reg - i0_reg - 1) + 1 > MaxLines) begin
                    st_next = ST_FULL; state_next = S_OUT;
                end else begin
                    raddr = IdxW'(i0_reg); state_next = S_TRIM_HI;
                end
            end
            S_TRIM_HI: begin
                if (i0_reg >= 0 && 64'(r_hi) > lb_reg - 1) begin
                    we = 1'b1; waddr = IdxW'(i0_reg);
                    wdata = {32'(lb_reg - 1), rd_reg[95:0]};
                end
                raddr = IdxW'(i1_reg); state_next = S_TRIM_LO;
            end
            S_TRIM_LO: begin
                if (i1_reg < cnt_s && 64'(r_lo) < ub_reg + 1) begin
                    we = 1'b1; waddr = IdxW'(i1_reg);
                    wdata = {rd_reg[127:96], 32'(ub_reg + 1), rd_reg[63:0]};
                end
                // shift direction follows new position against first kept upper line
                if (i1_reg < cnt_s && i1_reg != i0_reg + 2) begin
                    mv_next = (i1_reg > i0_reg + 2) ? '0 : cnt_s - 2'sd1;
                    state_next = S_MOVE_RD;
                end else state_next = S_PUT;
            end
            // move tail i1.. to i0+2.., ascending when closing up, descending when opening
            S_MOVE_RD: begin
                if (i1_reg > i0_reg + 2) raddr = IdxW'(i1_reg + mv_reg);
                else raddr = IdxW'(mv_reg);
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                we = 1'b1; wdata = rd_reg;
                if (i1_reg > i0_reg + 2) begin
                    waddr = IdxW'(i0_reg + 2 + mv_reg);
                    mv_next = mv_reg + 2'sd1;
                    state_next = (i1_reg + mv_reg + 1 < cnt_s) ? S_MOVE_RD : S_PUT;
                end else begin
                    waddr = IdxW'(mv_reg + 1);
                    mv_next = mv_reg - 2'sd1;
                    state_next = (mv_reg - 1 >= i1_reg) ? S_MOVE_RD : S_PUT;
                end
            end
            S_PUT: begin
                we = 1'b1; waddr = IdxW'(i0_reg + 1);
                wdata = {32'(ub_reg), 32'(lb_reg), b_reg, a_reg};
                count_next = CntW'(cnt_s - (i1_reg - i0_reg - 1) + 1);
                st_next = ST_INSERTED; state_next = S_OUT;
            end
            // query: last line whose low bound is at or below x
            S_Q_RD: begin
                raddr = IdxW'(p_reg); state_next = S_Q_SCAN;
            end
            S_Q_SCAN: begin
                if (64'(r_lo) <= 64'(x_reg)) k_next = IdxW'(p_reg);
                p_next = p_reg + 2'sd1;
                if (p_reg + 1 < cnt_s) state_next = S_Q_RD;
                else begin
                    raddr = (64'(r_lo) <= 64'(x_reg)) ? IdxW'(p_reg) : k_reg;
                    state_next = S_Q_MUL;
                end
            end
            S_Q_MUL: begin
                prod_next = 64'(r_a) * 64'(x_reg);
                res_next = 64'(r_b);
                state_next = S_Q_SUM;
            end
            S_Q_SUM: begin
                res_next = prod_reg + res_reg;
                st_next = ST_QUERY_OK; state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_v_reg) begin
                    out_v_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* hdl/lelt_div.sv */
// serial signed divider with floor or ceiling rounding, one quotient bit per cycle
// depends on lelt_pkg
module lelt_div
    import lelt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(NumW + 1);

    logic [NumW-1:0]        mag_n_reg, mag_d_reg, quo_reg, rem_reg;
    logic                   neg_reg, ceil_reg, busy_reg, done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [NumW:0]          trial;
    logic [NumW-1:0]        rem_sh;
    logic signed [NumW-1:0] q_s;

    assign rem_sh = {rem_reg[NumW-2:0], mag_n_reg[NumW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, mag_d_reg};

    // restoring division on magnitudes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CW'(NumW);
                mag_n_reg <= req.num[NumW-1] ? NumW'(-req.num) : NumW'(req.num);
                mag_d_reg <= req.den[NumW-1] ? NumW'(-req.den) : NumW'(req.den);
                neg_reg   <= req.num[NumW-1] ^ req.den[NumW-1];
                ceil_reg  <= req.ceil_mode;
                rem_reg   <= '0;
                quo_reg   <= '0;
            end else if (busy_reg) begin
                mag_n_reg <= {mag_n_reg[NumW-2:0], 1'b0};
                if (!trial[NumW]) begin
                    rem_reg <= trial[NumW-1:0];
                    quo_reg <= {quo_reg[NumW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NumW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // rounding: truncated quotient adjusted by sign and remainder
    always_comb begin
        q_s = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
        if (rem_reg != '0) begin
            if (ceil_reg && !neg_reg) q_s = q_s + NumW'(1);
            if (!ceil_reg && neg_reg) q_s = q_s - NumW'(1);
        end
        rsp.done = done_reg;
        rsp.quot = q_s;
    end

endmodule

/* hdl/lelt_checker.sv */
// port-level checks for the lower envelope line table
// depends on lower_envelope_line_table_core ports; bound to it below
module lelt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // status codes stay in range
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4) else $error("bad status");

    // min_value zero unless query ok
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != 3'd3 |-> m_axis_tdata[66:3] == 64'd0)
        else $error("nonzero value");

    // no new input while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");

    // result held under stall
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

endmodule

bind lower_envelope_line_table_core lelt_checker u_lelt_checker (.*);
